### design/assert_macros.svh
// Assertion macros used by the odometry design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as en.
`define ASSERT_SAME(label, en, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (en) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after en.
`define ASSERT_NEXT(label, en, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (en) |=> (cons)) \
    else $error(msg);

`endif

### design/xdo_pkg.sv
// Types, constants and helper functions for the X-drive odometry block.
package xdo_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CORDIC,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_CK,
    OP_CG,
    OP_VX,
    OP_VY,
    OP_OM,
    OP_XC,
    OP_YS,
    OP_XS,
    OP_YC,
    OP_DX,
    OP_DY,
    OP_RATE,
    OP_DH
  } op_t;

  localparam int MAC_W    = 64;
  localparam int MPL_W    = 32;
  localparam int DQ_W     = 32;
  localparam int VEL_W    = 24;
  localparam int CS_W     = 18;
  localparam int CK_W     = 24;
  localparam int CG_W     = 28;
  localparam int W_W      = 27;
  localparam int RATE_W   = 40;
  localparam int MICROS_W = 20;
  localparam int CORDIC_N = 16;
  localparam int RADIUS_W = 16;
  localparam int GAIN_W   = 20;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd1;

  localparam logic [RADIUS_W-1:0] RADIUS_RST = 16'd4162;
  localparam logic [GAIN_W-1:0]   GAIN_RST   = 20'd85178;

  localparam logic [MPL_W-1:0] K_VXY  = 32'd5931642;
  localparam logic [MPL_W-1:0] K_RATE = 32'd683565276;
  localparam logic signed [31:0] CORDIC_X0 = 32'sd652032874;
  localparam logic [MICROS_W-1:0] MICROS_LIMIT = 20'd1000000;

  function automatic logic signed [31:0] atan_entry(input logic [3:0] i);
    logic signed [31:0] a;
    case (i)
      4'd0:    a = 32'sh20000000;
      4'd1:    a = 32'sh12E4051E;
      4'd2:    a = 32'sh09FB385B;
      4'd3:    a = 32'sh051111D4;
      4'd4:    a = 32'sh028B0D43;
      4'd5:    a = 32'sh0145D7E1;
      4'd6:    a = 32'sh00A2F61E;
      4'd7:    a = 32'sh00517C55;
      4'd8:    a = 32'sh0028BE53;
      4'd9:    a = 32'sh00145F2F;
      4'd10:   a = 32'sh000A2F98;
      4'd11:   a = 32'sh000517CC;
      4'd12:   a = 32'sh00028BE6;
      4'd13:   a = 32'sh000145F3;
      4'd14:   a = 32'sh0000A2FA;
      default: a = 32'sh0000517D;
    endcase
    return a;
  endfunction

  // Round half up, then shift right arithmetically.
  function automatic logic signed [MAC_W-1:0] rsh_r(input logic signed [MAC_W-1:0] v,
                                                    input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [MAC_W-1:0] v);
    logic signed [MAC_W-1:0] hi;
    logic signed [MAC_W-1:0] lo;
    logic signed [VEL_W-1:0] r;
    hi = (64'sd1 <<< (VEL_W - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) r = hi[VEL_W-1:0];
    else if (v < lo) r = lo[VEL_W-1:0];
    else r = v[VEL_W-1:0];
    return r;
  endfunction

endpackage

### design/xdrive_wheel_odometry.sv
// X-drive wheel odometry: body velocity fit and pose integration, bit-serial datapath.
//
// Input channel in_*: one beat carries the four wheel speeds and the step time in
// microseconds. Output channel out_*: one beat per input beat with pose x/y, heading
// and the three body velocities. Configuration: cfg_wr_en writes the wheel radius
// (index 0) or the rotation gain (index 1) from cfg_data; other indexes are dropped.
// Products run through one shift-and-add multiplier that retires one multiplier bit
// a cycle and stops at the last set bit; divisions by the step scale run on a
// restoring divider; sine and cosine come from a CORDIC rotation. An item whose step is out of
// range skips the CORDIC and the pose and heading update. in_tready is high only while
// no item is in the datapath. A finished result waits in the output register, so the
// next item is taken while the receiver stalls; that item holds at its end until the
// output register is free.
// Reset clears pose and heading, loads the default radius and gain and empties the
// output register.
`include "assert_macros.svh"

module xdrive_wheel_odometry #(
  parameter int POSE_BITS  = 32,
  parameter int ANGLE_BITS = 16,
  parameter int SPEED_BITS = 24
) (
  input  logic clk,
  input  logic rst_n,
  input  logic                           cfg_wr_en,
  input  logic [xdo_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [xdo_pkg::GAIN_W-1:0]     cfg_data,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // speed_front_left, speed_rear_left, speed_rear_right, speed_front_right, step_micros
  input  logic [((4*SPEED_BITS+xdo_pkg::MICROS_W+7)/8)*8-1:0] in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // pose_x, pose_y, heading, body_vel_x, body_vel_y, yaw_rate
  output logic [((2*POSE_BITS+ANGLE_BITS+3*xdo_pkg::VEL_W+7)/8)*8-1:0] out_tdata
);

  localparam int SUM_W   = SPEED_BITS + 2;
  localparam int OUT_RAW = 2 * POSE_BITS + ANGLE_BITS + 3 * xdo_pkg::VEL_W;
  localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;
  localparam logic [xdo_pkg::MAC_W-1:0] DIV_POSE = 64'd1000000;
  localparam logic [xdo_pkg::MAC_W-1:0] DIV_HEAD = 64'd1000000 << (32 - ANGLE_BITS);

  function automatic logic signed [POSE_BITS-1:0] sat_pose(
    input logic signed [xdo_pkg::MAC_W-1:0] v);
    logic signed [xdo_pkg::MAC_W-1:0] hi;
    logic signed [xdo_pkg::MAC_W-1:0] lo;
    logic signed [POSE_BITS-1:0] r;
    hi = (64'sd1 <<< (POSE_BITS - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) r = hi[POSE_BITS-1:0];
    else if (v < lo) r = lo[POSE_BITS-1:0];
    else r = v[POSE_BITS-1:0];
    return r;
  endfunction

  xdo_pkg::state_t state_r, state_nxt;
  xdo_pkg::op_t    op_r, op_nxt;

  logic [xdo_pkg::RADIUS_W-1:0] radius_r, radius_nxt;
  logic [xdo_pkg::GAIN_W-1:0]   gain_r, gain_nxt;

  logic signed [xdo_pkg::MAC_W-1:0] acc_r, acc_nxt;
  logic signed [xdo_pkg::MAC_W-1:0] mcand_r, mcand_nxt;
  logic [xdo_pkg::MPL_W-1:0]        mplier_r, mplier_nxt;
  logic                             neg_r, neg_nxt;

  logic signed [SUM_W-1:0] sx_r, sx_nxt, sy_r, sy_nxt, sw_r, sw_nxt;
  logic [xdo_pkg::MICROS_W-1:0] micros_r, micros_nxt;
  logic step_ok_r, step_ok_nxt;
  logic [xdo_pkg::CK_W-1:0] ck_r, ck_nxt;
  logic [xdo_pkg::CG_W-1:0] cg_r, cg_nxt;
  logic signed [xdo_pkg::VEL_W-1:0] vx_r, vx_nxt, vy_r, vy_nxt, om_r, om_nxt;
  logic signed [xdo_pkg::CS_W-1:0] c_r, c_nxt, s_r, s_nxt;
  logic signed [xdo_pkg::W_W-1:0] wx_r, wx_nxt, wy_r, wy_nxt;

  logic signed [31:0] cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  logic [3:0] it_r, it_nxt;
  logic flip_r, flip_nxt;

  logic [xdo_pkg::MAC_W-1:0] rem_r, rem_nxt;
  logic [xdo_pkg::DQ_W-1:0]  dq_r, dq_nxt;
  logic [5:0]                dcnt_r, dcnt_nxt;
  logic                      dneg_r, dneg_nxt;

  logic signed [POSE_BITS-1:0] pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic [ANGLE_BITS-1:0] head_r, head_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  logic signed [SPEED_BITS-1:0] fl, rl, rr, fr;
  logic [xdo_pkg::MICROS_W-1:0] in_micros;

  assign fl = in_tdata[SPEED_BITS-1:0];
  assign rl = in_tdata[2*SPEED_BITS-1:SPEED_BITS];
  assign rr = in_tdata[3*SPEED_BITS-1:2*SPEED_BITS];
  assign fr = in_tdata[4*SPEED_BITS-1:3*SPEED_BITS];
  assign in_micros = in_tdata[4*SPEED_BITS +: xdo_pkg::MICROS_W];

  assign in_tready  = (state_r == xdo_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  logic                             ld_en, ld_clr, ld_neg;
  logic signed [xdo_pkg::MAC_W-1:0] ld_a;
  logic [xdo_pkg::MPL_W-1:0]        ld_b;
  xdo_pkg::op_t                     ld_op;
  logic                             dv_en;
  logic [xdo_pkg::MAC_W-1:0]        dvsr, mag, trial;
  logic signed [xdo_pkg::MAC_W-1:0] dlt;
  logic signed [31:0]               nx, ny, sh_x, sh_y, c_full, s_full;
  logic signed [xdo_pkg::CS_W-1:0]  c_w, s_w, c_abs, s_abs;
  logic signed [xdo_pkg::MAC_W-1:0] rate_w;
  logic signed [31:0]               z32;
  logic                             head_upd;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    radius_nxt    = radius_r;
    gain_nxt      = gain_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    neg_nxt       = neg_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    sw_nxt        = sw_r;
    micros_nxt    = micros_r;
    step_ok_nxt   = step_ok_r;
    ck_nxt        = ck_r;
    cg_nxt        = cg_r;
    vx_nxt        = vx_r;
    vy_nxt        = vy_r;
    om_nxt        = om_r;
    c_nxt         = c_r;
    s_nxt         = s_r;
    wx_nxt        = wx_r;
    wy_nxt        = wy_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    cz_nxt        = cz_r;
    it_nxt        = it_r;
    flip_nxt      = flip_r;
    rem_nxt       = rem_r;
    dq_nxt        = dq_r;
    dcnt_nxt      = dcnt_r;
    dneg_nxt      = dneg_r;
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    head_nxt      = head_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    ld_en  = 1'b0;
    ld_clr = 1'b1;
    ld_neg = 1'b0;
    ld_a   = '0;
    ld_b   = '0;
    ld_op  = op_r;
    dv_en  = 1'b0;
    head_upd = 1'b0;

    dvsr  = (op_r == xdo_pkg::OP_DH) ? DIV_HEAD : DIV_POSE;
    mag   = ((acc_r < 0) ? 64'(-acc_r) : 64'(acc_r)) + (dvsr >> 1);
    trial = {rem_r[xdo_pkg::MAC_W-2:0], dq_r[xdo_pkg::DQ_W-1]};
    dlt   = dneg_r ? -$signed({32'd0, dq_r}) : $signed({32'd0, dq_r});

    sh_x   = cx_r >>> it_r;
    sh_y   = cy_r >>> it_r;
    nx     = cz_r[31] ? (cx_r + sh_y) : (cx_r - sh_y);
    ny     = cz_r[31] ? (cy_r - sh_x) : (cy_r + sh_x);
    c_full = (nx + 32'sd8192) >>> 14;
    s_full = (ny + 32'sd8192) >>> 14;
    c_w    = xdo_pkg::CS_W'(flip_r ? -c_full : c_full);
    s_w    = xdo_pkg::CS_W'(flip_r ? -s_full : s_full);
    c_abs  = c_r[xdo_pkg::CS_W-1] ? -c_r : c_r;
    s_abs  = s_r[xdo_pkg::CS_W-1] ? -s_r : s_r;
    rate_w = xdo_pkg::rsh_r(acc_r, 16);
    z32    = {head_r, (32 - ANGLE_BITS)'(0)};

    if (cfg_wr_en) begin
      unique case (cfg_index)
        xdo_pkg::CFG_RADIUS: radius_nxt = cfg_data[xdo_pkg::RADIUS_W-1:0];
        xdo_pkg::CFG_GAIN:   gain_nxt   = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      xdo_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          sx_nxt = SUM_W'(fl) + SUM_W'(rl) + SUM_W'(rr) + SUM_W'(fr);
          sy_nxt = -SUM_W'(fl) + SUM_W'(rl) - SUM_W'(rr) + SUM_W'(fr);
          sw_nxt = -SUM_W'(fl) - SUM_W'(rl) + SUM_W'(rr) + SUM_W'(fr);
          micros_nxt  = in_micros;
          step_ok_nxt = (in_micros != '0) && (in_micros < xdo_pkg::MICROS_LIMIT);
          ld_en = 1'b1;
          ld_a  = $signed(64'(radius_r));
          ld_b  = xdo_pkg::K_VXY;
          ld_op = xdo_pkg::OP_CK;
        end
      end
      xdo_pkg::ST_MUL: begin
        if (mplier_r != '0) begin
          if (mplier_r[0]) acc_nxt = neg_r ? (acc_r - mcand_r) : (acc_r + mcand_r);
          mcand_nxt  = mcand_r <<< 1;
          mplier_nxt = mplier_r >> 1;
        end else begin
          unique case (op_r)
            xdo_pkg::OP_CK: begin
              ck_nxt = xdo_pkg::CK_W'(xdo_pkg::rsh_r(acc_r, 16));
              ld_en = 1'b1;
              ld_a  = $signed(64'(radius_r));
              ld_b  = 32'(gain_r);
              ld_op = xdo_pkg::OP_CG;
            end
            xdo_pkg::OP_CG: begin
              cg_nxt = xdo_pkg::CG_W'(xdo_pkg::rsh_r(acc_r, 8));
              ld_en = 1'b1;
              ld_a  = 64'(sx_r);
              ld_b  = 32'(ck_r);
              ld_op = xdo_pkg::OP_VX;
            end
            xdo_pkg::OP_VX: begin
              vx_nxt = xdo_pkg::sat_vel(xdo_pkg::rsh_r(acc_r, 20));
              ld_en = 1'b1;
              ld_a  = 64'(sy_r);
              ld_b  = 32'(ck_r);
              ld_op = xdo_pkg::OP_VY;
            end
            xdo_pkg::OP_VY: begin
              vy_nxt = xdo_pkg::sat_vel(xdo_pkg::rsh_r(acc_r, 20));
              ld_en = 1'b1;
              ld_a  = 64'(sw_r);
              ld_b  = 32'(cg_r);
              ld_op = xdo_pkg::OP_OM;
            end
            xdo_pkg::OP_OM: begin
              om_nxt = xdo_pkg::sat_vel(xdo_pkg::rsh_r(acc_r, 20));
              if (step_ok_r) begin
                flip_nxt  = z32[31] ^ z32[30];
                cz_nxt    = (z32[31] ^ z32[30]) ? (z32 ^ 32'sh80000000) : z32;
                cx_nxt    = xdo_pkg::CORDIC_X0;
                cy_nxt    = '0;
                it_nxt    = '0;
                state_nxt = xdo_pkg::ST_CORDIC;
              end else begin
                state_nxt = xdo_pkg::ST_OUT;
              end
            end
            xdo_pkg::OP_XC: begin
              ld_en  = 1'b1;
              ld_clr = 1'b0;
              ld_a   = 64'(vy_r);
              ld_b   = 32'(s_abs);
              ld_neg = ~s_r[xdo_pkg::CS_W-1];
              ld_op  = xdo_pkg::OP_YS;
            end
            xdo_pkg::OP_YS: begin
              wx_nxt = xdo_pkg::W_W'(xdo_pkg::rsh_r(acc_r, 16));
              ld_en  = 1'b1;
              ld_a   = 64'(vx_r);
              ld_b   = 32'(s_abs);
              ld_neg = s_r[xdo_pkg::CS_W-1];
              ld_op  = xdo_pkg::OP_XS;
            end
            xdo_pkg::OP_XS: begin
              ld_en  = 1'b1;
              ld_clr = 1'b0;
              ld_a   = 64'(vy_r);
              ld_b   = 32'(c_abs);
              ld_neg = c_r[xdo_pkg::CS_W-1];
              ld_op  = xdo_pkg::OP_YC;
            end
            xdo_pkg::OP_YC: begin
              wy_nxt = xdo_pkg::W_W'(xdo_pkg::rsh_r(acc_r, 16));
              ld_en = 1'b1;
              ld_a  = 64'(wx_r);
              ld_b  = 32'(micros_r);
              ld_op = xdo_pkg::OP_DX;
            end
            xdo_pkg::OP_RATE: begin
              ld_en = 1'b1;
              ld_a  = 64'(xdo_pkg::RATE_W'(rate_w));
              ld_b  = 32'(micros_r);
              ld_op = xdo_pkg::OP_DH;
            end
            xdo_pkg::OP_DX, xdo_pkg::OP_DY, xdo_pkg::OP_DH: begin
              dv_en = 1'b1;
            end
            default: state_nxt = xdo_pkg::ST_OUT;
          endcase
        end
      end
      xdo_pkg::ST_CORDIC: begin
        cx_nxt = nx;
        cy_nxt = ny;
        cz_nxt = cz_r[31] ? (cz_r + xdo_pkg::atan_entry(it_r))
                          : (cz_r - xdo_pkg::atan_entry(it_r));
        it_nxt = it_r + 4'd1;
        if (it_r == 4'(xdo_pkg::CORDIC_N - 1)) begin
          c_nxt  = c_w;
          s_nxt  = s_w;
          ld_en  = 1'b1;
          ld_a   = 64'(vx_r);
          ld_b   = 32'(c_w[xdo_pkg::CS_W-1] ? -c_w : c_w);
          ld_neg = c_w[xdo_pkg::CS_W-1];
          ld_op  = xdo_pkg::OP_XC;
        end
      end
      xdo_pkg::ST_DIV: begin
        if (dcnt_r != '0) begin
          if (trial >= dvsr) begin
            rem_nxt = trial - dvsr;
            dq_nxt  = {dq_r[xdo_pkg::DQ_W-2:0], 1'b1};
          end else begin
            rem_nxt = trial;
            dq_nxt  = {dq_r[xdo_pkg::DQ_W-2:0], 1'b0};
          end
          dcnt_nxt = dcnt_r - 6'd1;
        end else begin
          unique case (op_r)
            xdo_pkg::OP_DX: begin
              pos_x_nxt = sat_pose(64'(pos_x_r) + dlt);
              ld_en = 1'b1;
              ld_a  = 64'(wy_r);
              ld_b  = 32'(micros_r);
              ld_op = xdo_pkg::OP_DY;
            end
            xdo_pkg::OP_DY: begin
              pos_y_nxt = sat_pose(64'(pos_y_r) + dlt);
              ld_en = 1'b1;
              ld_a  = 64'(om_r);
              ld_b  = xdo_pkg::K_RATE;
              ld_op = xdo_pkg::OP_RATE;
            end
            xdo_pkg::OP_DH: begin
              head_upd  = 1'b1;
              head_nxt  = dneg_r ? (head_r - dq_r[ANGLE_BITS-1:0])
                                 : (head_r + dq_r[ANGLE_BITS-1:0]);
              state_nxt = xdo_pkg::ST_OUT;
            end
            default: state_nxt = xdo_pkg::ST_OUT;
          endcase
        end
      end
      xdo_pkg::ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_W'({om_r, vy_r, vx_r, head_r, pos_y_r, pos_x_r});
          state_nxt     = xdo_pkg::ST_IDLE;
        end
      end
      default: state_nxt = xdo_pkg::ST_IDLE;
    endcase

    if (ld_en) begin
      if (ld_clr) acc_nxt = '0;
      mcand_nxt  = ld_a;
      mplier_nxt = ld_b;
      neg_nxt    = ld_neg;
      op_nxt     = ld_op;
      state_nxt  = xdo_pkg::ST_MUL;
    end
    if (dv_en) begin
      dneg_nxt  = acc_r[xdo_pkg::MAC_W-1];
      rem_nxt   = mag >> xdo_pkg::DQ_W;
      dq_nxt    = mag[xdo_pkg::DQ_W-1:0];
      dcnt_nxt  = 6'(xdo_pkg::DQ_W);
      state_nxt = xdo_pkg::ST_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= xdo_pkg::ST_IDLE;
      op_r        <= xdo_pkg::OP_CK;
      radius_r    <= xdo_pkg::RADIUS_RST;
      gain_r      <= xdo_pkg::GAIN_RST;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      radius_r    <= radius_nxt;
      gain_r      <= gain_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    mcand_r    <= mcand_nxt;
    mplier_r   <= mplier_nxt;
    neg_r      <= neg_nxt;
    sx_r       <= sx_nxt;
    sy_r       <= sy_nxt;
    sw_r       <= sw_nxt;
    micros_r   <= micros_nxt;
    step_ok_r  <= step_ok_nxt;
    ck_r       <= ck_nxt;
    cg_r       <= cg_nxt;
    vx_r       <= vx_nxt;
    vy_r       <= vy_nxt;
    om_r       <= om_nxt;
    c_r        <= c_nxt;
    s_r        <= s_nxt;
    wx_r       <= wx_nxt;
    wy_r       <= wy_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    cz_r       <= cz_nxt;
    it_r       <= it_nxt;
    flip_r     <= flip_nxt;
    rem_r      <= rem_nxt;
    dq_r       <= dq_nxt;
    dcnt_r     <= dcnt_nxt;
    dneg_r     <= dneg_nxt;
    out_data_r <= out_data_nxt;
  end

  `ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "accepted twice")
  `ASSERT_SAME(a_out_from_end, $rose(out_valid_r), $past(state_r == xdo_pkg::ST_OUT),
               "result raised outside end state")
  `ASSERT_NEXT(a_head_hold, rst_n && !head_upd, $stable(head_r),
               "heading moved without update")

endmodule

### sim/xdrive_wheel_odometry_tb.sv
// Self-checking testbench for the X-drive wheel odometry block.
module xdrive_wheel_odometry_tb;

  localparam int IN_W   = 120;
  localparam int OUT_W  = 152;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int HOLD_OFF_CYCLES = 900;
  localparam longint MICROS_PER_S = 1000000;

  typedef struct packed {
    logic [31:0] pose_x;
    logic [31:0] pose_y;
    logic [15:0] heading;
    logic [23:0] vel_x;
    logic [23:0] vel_y;
    logic [23:0] yaw_rate;
  } odo_t;

  localparam longint ATAN_LUT [16] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
  };

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [xdo_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [xdo_pkg::GAIN_W-1:0] cfg_data;
  logic in_tvalid;
  logic in_tready;
  // speed_front_left, speed_rear_left, speed_rear_right, speed_front_right, step_micros
  logic [IN_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  // pose_x, pose_y, heading, body_vel_x, body_vel_y, yaw_rate
  logic [OUT_W-1:0] out_tdata;

  xdrive_wheel_odometry uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  logic [IN_W-1:0] wheel_beats [$];
  odo_t pose_due [$];
  longint radius_m, gain_m;
  longint pos_x_m, pos_y_m;
  logic [15:0] heading_m;
  int errors;
  int results_seen;
  int stall_cnt;
  int hold_cnt;
  bit hold_done;
  bit steady;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint rnd_sh(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint div_round(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic longint clamp(longint v, int w);
    longint hi;
    hi = (64'sd1 <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  task automatic heading_sincos(input logic [15:0] ang, output longint c, output longint s);
    logic [31:0] z32;
    bit flip;
    longint x, y, z, nx;
    z32 = {ang, 16'b0};
    flip = (z32[31:30] == 2'd1) || (z32[31:30] == 2'd2);
    if (flip) z32 = z32 + 32'h80000000;
    z = longint'(signed'(z32));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - ATAN_LUT[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + ATAN_LUT[i];
      end
      x = nx;
    end
    c = rnd_sh(x, 14);
    s = rnd_sh(y, 14);
    if (flip) begin
      c = -c;
      s = -s;
    end
  endtask

  task automatic advance_pose(input logic [IN_W-1:0] beat, output odo_t res);
    longint fl, rl, rr, fr, us, sx, sy, sw, ck, cg, vx, vy, om, c, s, wx, wy, rate, dh;
    fl = longint'(signed'(beat[23:0]));
    rl = longint'(signed'(beat[47:24]));
    rr = longint'(signed'(beat[71:48]));
    fr = longint'(signed'(beat[95:72]));
    us = longint'(beat[115:96]);
    sx = fl + rl + rr + fr;
    sy = -fl + rl - rr + fr;
    sw = -fl - rl + rr + fr;
    ck = rnd_sh(radius_m * 5931642, 16);
    cg = rnd_sh(radius_m * gain_m, 8);
    vx = clamp(rnd_sh(sx * ck, 20), 24);
    vy = clamp(rnd_sh(sy * ck, 20), 24);
    om = clamp(rnd_sh(sw * cg, 20), 24);
    if (us > 0 && us < MICROS_PER_S) begin
      heading_sincos(heading_m, c, s);
      wx = rnd_sh(vx * c - vy * s, 16);
      wy = rnd_sh(vx * s + vy * c, 16);
      pos_x_m = clamp(pos_x_m + div_round(wx * us, MICROS_PER_S), 32);
      pos_y_m = clamp(pos_y_m + div_round(wy * us, MICROS_PER_S), 32);
      rate = rnd_sh(om * 683565276, 16);
      dh = div_round(rate * us, MICROS_PER_S <<< 16);
      heading_m = heading_m + dh[15:0];
    end
    res.pose_x = pos_x_m[31:0];
    res.pose_y = pos_y_m[31:0];
    res.heading = heading_m;
    res.vel_x = vx[23:0];
    res.vel_y = vy[23:0];
    res.yaw_rate = om[23:0];
  endtask

  function automatic logic [IN_W-1:0] wheel_beat(logic [23:0] fl, logic [23:0] rl,
                                                 logic [23:0] rr, logic [23:0] fr,
                                                 logic [19:0] us);
    return {4'b0, us, fr, rr, rl, fl};
  endfunction

  function automatic logic [23:0] rand_speed();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(16383)) - 8192);
      2: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
      default: return 24'($signed($urandom_range(262143)) - 131072);
    endcase
  endfunction

  function automatic logic [19:0] rand_micros();
    case ($urandom_range(9))
      0: return $urandom_range(1) ? 20'd0 : 20'($urandom_range(1048575, 1000000));
      1: return $urandom_range(1) ? 20'd1 : 20'd999999;
      2: return 20'($urandom_range(999999, 1));
      default: return 20'($urandom_range(20000, 1));
    endcase
  endfunction

  task automatic write_reg(input logic [xdo_pkg::CFG_IDX_W-1:0] idx,
                           input logic [xdo_pkg::GAIN_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == xdo_pkg::CFG_RADIUS) radius_m = longint'(val[15:0]);
    else if (idx == xdo_pkg::CFG_GAIN) gain_m = longint'(val);
  endtask

  task automatic drain();
    while (wheel_beats.size() != 0 || pose_due.size() != 0 || in_tvalid) @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  task automatic queue_random(input int n);
    repeat (n) wheel_beats.push_back(wheel_beat(rand_speed(), rand_speed(), rand_speed(),
                                                rand_speed(), rand_micros()));
  endtask

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        odo_t r;
        advance_pose(in_tdata, r);
        pose_due.push_back(r);
      end
      if (!in_tvalid || in_tready) begin
        if (wheel_beats.size() != 0 && (steady || $urandom_range(99) >= 26)) begin
          in_tdata <= wheel_beats.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver with one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_cnt <= 0;
      hold_done <= 1'b0;
    end else if (hold_cnt > 0) begin
      out_tready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (!hold_done && results_seen == 120) begin
      out_tready <= 1'b0;
      hold_cnt <= HOLD_OFF_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_tready <= steady || $urandom_range(99) >= 26;
    end
  end

  // Monitor and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cnt <= 0;
      results_seen <= 0;
    end else begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt > WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
      if (out_tvalid && out_tready) begin
        odo_t got, want;
        got.pose_x = out_tdata[31:0];
        got.pose_y = out_tdata[63:32];
        got.heading = out_tdata[79:64];
        got.vel_x = out_tdata[103:80];
        got.vel_y = out_tdata[127:104];
        got.yaw_rate = out_tdata[151:128];
        results_seen <= results_seen + 1;
        if (pose_due.size() == 0) begin
          $error("unexpected result beat");
          errors++;
        end else begin
          want = pose_due.pop_front();
          if (got.pose_x !== want.pose_x) begin
            $error("pose_x exp %h got %h", want.pose_x, got.pose_x); errors++;
          end
          if (got.pose_y !== want.pose_y) begin
            $error("pose_y exp %h got %h", want.pose_y, got.pose_y); errors++;
          end
          if (got.heading !== want.heading) begin
            $error("heading exp %h got %h", want.heading, got.heading); errors++;
          end
          if (got.vel_x !== want.vel_x) begin
            $error("body_vel_x exp %h got %h", want.vel_x, got.vel_x); errors++;
          end
          if (got.vel_y !== want.vel_y) begin
            $error("body_vel_y exp %h got %h", want.vel_y, got.vel_y); errors++;
          end
          if (got.yaw_rate !== want.yaw_rate) begin
            $error("yaw_rate exp %h got %h", want.yaw_rate, got.yaw_rate); errors++;
          end
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    steady = 1'b0;
    radius_m = 4162;
    gain_m = 85178;
    pos_x_m = 0;
    pos_y_m = 0;
    heading_m = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, step edges, pure motions
    wheel_beats.push_back(wheel_beat(24'h0, 24'h0, 24'h0, 24'h0, 20'd0));
    wheel_beats.push_back(wheel_beat(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 20'd1));
    wheel_beats.push_back(wheel_beat(24'h800000, 24'h800000, 24'h800000, 24'h800000,
                                     20'd999999));
    wheel_beats.push_back(wheel_beat(24'h001000, 24'h001000, 24'h001000, 24'h001000,
                                     20'd1000000));
    wheel_beats.push_back(wheel_beat(24'h001000, 24'h001000, 24'h001000, 24'h001000,
                                     20'hFFFFF));
    wheel_beats.push_back(wheel_beat(24'hFFF000, 24'h001000, 24'hFFF000, 24'h001000,
                                     20'd500000));
    wheel_beats.push_back(wheel_beat(24'hFF0000, 24'hFF0000, 24'h010000, 24'h010000,
                                     20'd999999));
    wheel_beats.push_back(wheel_beat(24'hFF0000, 24'hFF0000, 24'h010000, 24'h010000,
                                     20'd999999));
    wheel_beats.push_back(wheel_beat(24'h002000, 24'h002000, 24'h002000, 24'h002000,
                                     20'd250000));
    wheel_beats.push_back(wheel_beat(24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF,
                                     20'd10000));
    wheel_beats.push_back(wheel_beat(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000,
                                     20'd10000));
    drain();

    // zero registers, ignored indexes
    write_reg(xdo_pkg::CFG_RADIUS, 20'h00000);
    write_reg(xdo_pkg::CFG_GAIN, 20'h00000);
    write_reg(2'd2, 20'hFFFFF);
    write_reg(2'd3, 20'hAAAAA);
    queue_random(8);
    drain();

    // extremes
    write_reg(xdo_pkg::CFG_RADIUS, 20'hFFFFF);
    write_reg(xdo_pkg::CFG_GAIN, 20'hFFFFF);
    queue_random(200);
    drain();

    write_reg(xdo_pkg::CFG_RADIUS, 20'd1);
    write_reg(xdo_pkg::CFG_GAIN, 20'd1);
    steady = 1'b1;
    queue_random(100);
    drain();
    steady = 1'b0;

    // drive straight until position saturates, then back off the rail
    write_reg(xdo_pkg::CFG_RADIUS, 20'd65535);
    write_reg(xdo_pkg::CFG_GAIN, 20'd0);
    repeat (280) wheel_beats.push_back(wheel_beat(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                                                  24'h7FFFFF, 20'd999999));
    repeat (20) wheel_beats.push_back(wheel_beat(24'h800000, 24'h800000, 24'h800000,
                                                 24'h800000, 20'($urandom_range(999999, 1))));
    drain();

    write_reg(xdo_pkg::CFG_RADIUS, 20'($urandom_range(65535, 1)));
    write_reg(xdo_pkg::CFG_GAIN, 20'($urandom_range(1048575, 1)));
    queue_random(50);
    drain();
    write_reg(xdo_pkg::CFG_RADIUS, 20'd4162);
    write_reg(xdo_pkg::CFG_GAIN, 20'd85178);
    queue_random(100);
    drain();

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
